// ===== design/trr_pkg.sv =====
// Shared constants and types for the tolerant rank block.
`default_nettype none
package trr_pkg;
    localparam int MAX_CELLS = 64;
    localparam int IDX_W     = $clog2(MAX_CELLS);
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int VAL_W     = 32;
    localparam int KEY_W     = 16;
    localparam int TOL_W     = 31;
    localparam int RANK_W    = 7;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic             dropped;
    } job_t;
endpackage
`default_nettype wire

// ===== design/trr_if.sv =====
// Valid/ready channel interfaces for input items and result beats.
`default_nettype none
interface trr_in_if;
    logic                           valid;
    logic                           ready;
    logic signed [trr_pkg::VAL_W-1:0] value;
    logic [trr_pkg::KEY_W-1:0]      tie_key;
    logic                           last_cell;
    modport source (output valid, value, tie_key, last_cell, input ready);
    modport sink   (input valid, value, tie_key, last_cell, output ready);
endinterface

interface trr_out_if;
    logic                            valid;
    logic                            ready;
    logic [trr_pkg::IDX_W-1:0]       cell_index;
    logic [trr_pkg::RANK_W-1:0]      rank;
    logic                            overflow;
    logic                            last_rank;
    modport source (output valid, cell_index, rank, overflow, last_rank, input ready);
    modport sink   (input valid, cell_index, rank, overflow, last_rank, output ready);
endinterface
`default_nettype wire

// ===== design/trr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module trr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/trr_front.sv =====
// Front end: loads items into the stores and hands a finished set to the back end.
`default_nettype none
module trr_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    trr_in_if.sink                           in_ch,
    input  wire logic                        back_busy,
    input  wire logic                        job_pop,
    output logic                             job_valid,
    output trr_pkg::job_t                    job,
    output logic                             st_we,
    output logic [trr_pkg::IDX_W-1:0]        st_addr,
    output logic [trr_pkg::VAL_W-1:0]        st_value,
    output logic [trr_pkg::KEY_W-1:0]        st_key
);
    logic [trr_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      drop_reg, drop_next;
    logic                      jv_reg, jv_next;
    trr_pkg::job_t             job_reg, job_next;
    logic                      acc, room;

    // one-entry job queue; the stores are single-set, so loading waits for the back end
    assign in_ch.ready = !jv_reg && !back_busy;
    assign acc         = in_ch.valid && in_ch.ready;
    assign room        = cnt_reg < trr_pkg::CNT_W'(trr_pkg::MAX_CELLS);

    assign st_we    = acc && room;
    assign st_addr  = cnt_reg[trr_pkg::IDX_W-1:0];
    assign st_value = in_ch.value;
    assign st_key   = in_ch.tie_key;
    assign job_valid = jv_reg;
    assign job       = job_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        drop_next = drop_reg;
        jv_next   = jv_reg && !job_pop;
        job_next  = job_reg;
        if (acc)
        begin
            if (room)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            else
            begin
                drop_next = 1'b1;
            end
            if (in_ch.last_cell)
            begin
                jv_next          = 1'b1;
                job_next.n       = cnt_next;
                job_next.dropped = drop_next;
                cnt_next         = '0;
                drop_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
            jv_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            drop_reg <= drop_next;
            jv_reg   <= jv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end
endmodule
`default_nettype wire

// ===== design/trr_back.sv =====
// Back end: two counting sorts and the tolerance walk, then emits ranks in arrival order.
`default_nettype none
module trr_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [trr_pkg::TOL_W-1:0]   tolerance,
    input  wire logic                        job_valid,
    input  wire trr_pkg::job_t               job,
    output logic                             job_pop,
    output logic                             busy,
    output logic [trr_pkg::IDX_W-1:0]        val_raddr,
    input  wire logic [trr_pkg::VAL_W-1:0]   val_rdata,
    output logic [trr_pkg::IDX_W-1:0]        key_raddr,
    input  wire logic [trr_pkg::KEY_W-1:0]   key_rdata,
    trr_out_if.source                        out_ch
);
    localparam int IW = trr_pkg::IDX_W;
    localparam int VW = trr_pkg::VAL_W;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_LDI  = 10'b0000000010,
        S_CAP  = 10'b0000000100,
        S_SWP  = 10'b0000001000,
        S_DRN  = 10'b0000010000,
        S_FIN  = 10'b0000100000,
        S_ERO  = 10'b0001000000,
        S_ERV  = 10'b0010000000,
        S_EWR  = 10'b0100000000,
        S_EMIT = 10'b1000000000
    } state_t;

    state_t                  st_reg, st_next;
    logic                    pass2_reg, pass2_next;
    logic [trr_pkg::CNT_W-1:0] n_reg, n_next;
    logic                    drop_reg, drop_next;
    logic [IW-1:0]           i_reg, i_next, j_reg, j_next, cnt_reg, cnt_next;
    logic                    cmpv_reg;
    logic [IW-1:0]           cmpj_reg;
    logic signed [VW-1:0]    vi_reg, vi_next, base_reg, base_next;
    logic [trr_pkg::KEY_W-1:0] ki_reg, ki_next;
    logic [IW-1:0]           eidx_reg, eidx_next;

    logic                    ov_reg, ov_next, ol_reg, ol_next;
    logic [IW-1:0]           oi_reg, oi_next;
    logic [trr_pkg::RANK_W-1:0] or_reg, or_next;
    logic                    oo_reg, oo_next;

    logic [IW-1:0]           ord_rdata, adj_raddr;
    logic [VW-1:0]           adj_rdata, adj_wdata;
    logic                    ord_we, adj_we, last_i, last_j, less, in_tol;
    logic signed [VW-1:0]    cur_v;
    logic signed [VW:0]      diff;

    trr_ram #(.WIDTH(IW), .DEPTH(trr_pkg::MAX_CELLS)) u_ord (
        .clk(clk), .we(ord_we), .waddr(cnt_reg), .wdata(i_reg),
        .raddr(i_reg), .rdata(ord_rdata));

    trr_ram #(.WIDTH(VW), .DEPTH(trr_pkg::MAX_CELLS)) u_adj (
        .clk(clk), .we(adj_we), .waddr(eidx_reg), .wdata(adj_wdata),
        .raddr(adj_raddr), .rdata(adj_rdata));

    assign last_i    = {1'b0, i_reg} == n_reg - 1'b1;
    assign last_j    = {1'b0, j_reg} == n_reg - 1'b1;
    assign adj_raddr = (st_reg == S_LDI) ? i_reg : j_reg;
    assign key_raddr = adj_raddr;
    assign val_raddr = (st_reg == S_ERV) ? ord_rdata : adj_raddr;
    assign busy      = (st_reg != S_IDLE);
    assign job_pop   = (st_reg == S_IDLE) && job_valid;

    assign cur_v = pass2_reg ? $signed(adj_rdata) : $signed(val_rdata);

    // (value, arrival) order in pass 1; (adjusted value, key, arrival) in pass 2
    always_comb
    begin
        if (cur_v != vi_reg)
        begin
            less = cur_v < vi_reg;
        end
        else if (pass2_reg && (key_rdata != ki_reg))
        begin
            less = key_rdata < ki_reg;
        end
        else
        begin
            less = cmpj_reg < i_reg;
        end
    end

    assign diff   = {val_rdata[VW-1], val_rdata} - {base_reg[VW-1], base_reg};
    assign in_tol = diff <= $signed({2'b00, tolerance});
    assign ord_we = (st_reg == S_FIN) && !pass2_reg;
    assign adj_we = (st_reg == S_EWR);
    assign adj_wdata = ((i_reg != '0) && in_tol) ? base_reg : val_rdata;

    always_comb
    begin
        st_next    = st_reg;
        pass2_next = pass2_reg;
        n_next     = n_reg;
        drop_next  = drop_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        vi_next    = vi_reg;
        ki_next    = ki_reg;
        base_next  = base_reg;
        eidx_next  = eidx_reg;
        ov_next    = ov_reg && !out_ch.ready;
        oi_next    = oi_reg;
        or_next    = or_reg;
        oo_next    = oo_reg;
        ol_next    = ol_reg;
        if (cmpv_reg && less)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        unique case (st_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    n_next     = job.n;
                    drop_next  = job.dropped;
                    pass2_next = 1'b0;
                    i_next     = '0;
                    st_next    = S_LDI;
                end
            end
            S_LDI:
            begin
                st_next = S_CAP;
            end
            S_CAP:
            begin
                vi_next  = cur_v;
                ki_next  = key_rdata;
                j_next   = '0;
                cnt_next = '0;
                st_next  = S_SWP;
            end
            S_SWP:
            begin
                j_next = j_reg + 1'b1;
                if (last_j)
                begin
                    st_next = S_DRN;
                end
            end
            S_DRN:
            begin
                st_next = pass2_reg ? S_EMIT : S_FIN;
            end
            S_FIN:
            begin
                i_next = i_reg + 1'b1;
                if (last_i)
                begin
                    i_next  = '0;
                    st_next = S_ERO;
                end
                else
                begin
                    st_next = S_LDI;
                end
            end
            S_ERO:
            begin
                st_next = S_ERV;
            end
            S_ERV:
            begin
                eidx_next = ord_rdata;
                st_next   = S_EWR;
            end
            S_EWR:
            begin
                if ((i_reg == '0) || !in_tol)
                begin
                    base_next = $signed(val_rdata);
                end
                i_next = i_reg + 1'b1;
                if (last_i)
                begin
                    i_next     = '0;
                    pass2_next = 1'b1;
                    st_next    = S_LDI;
                end
                else
                begin
                    st_next = S_ERO;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next = 1'b1;
                    oi_next = i_reg;
                    or_next = {1'b0, cnt_reg} + 1'b1;
                    oo_next = drop_reg;
                    ol_next = last_i;
                    i_next  = i_reg + 1'b1;
                    st_next = last_i ? S_IDLE : S_LDI;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            cmpv_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cmpv_reg <= (st_reg == S_SWP);
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pass2_reg <= pass2_next;
        n_reg     <= n_next;
        drop_reg  <= drop_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        cnt_reg   <= cnt_next;
        cmpj_reg  <= j_reg;
        vi_reg    <= vi_next;
        ki_reg    <= ki_next;
        base_reg  <= base_next;
        eidx_reg  <= eidx_next;
        oi_reg    <= oi_next;
        or_reg    <= or_next;
        oo_reg    <= oo_next;
        ol_reg    <= ol_next;
    end

    assign out_ch.valid      = ov_reg;
    assign out_ch.cell_index = oi_reg;
    assign out_ch.rank       = or_reg;
    assign out_ch.overflow   = oo_reg;
    assign out_ch.last_rank  = ol_reg;
endmodule
`default_nettype wire

// ===== design/tolerant_rank_random_ties.sv =====
// Top level of the tolerant rank block with random tie-break keys.
// Input channel in_ch: one beat per cell (value, tie_key, last_cell). Beats load
// the value and key stores; the beat with last_cell set closes the set. Beats past
// 64 cells are dropped and set overflow on every rank of that set.
// Output channel out_ch: one beat per stored cell in arrival order with its rank.
// Configuration: cfg_we writes cfg_wdata into the tolerance register; write it only
// while the block is idle.
// Sequence: loading stores one cell per accepted beat. After the closing beat the
// back end runs a counting sort over the value store, a tolerance walk and a
// second counting sort that emits one rank at the end of each sweep; the full
// compare sweep per cell in both counting sorts dominates the run time.
// in_ch.ready stays low from the closing beat until the last rank has been
// placed in the output register.
// A stalled receiver holds the output register and pauses the back end.
// Reset clears the tolerance, the load count, the overflow flag, the FSM state and
// the valid flags; store contents and the back end's counters are not cleared.
`default_nettype none
module tolerant_rank_random_ties (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [trr_pkg::TOL_W-1:0]   cfg_wdata,
    trr_in_if.sink                           in_ch,
    trr_out_if.source                        out_ch
);
    logic [trr_pkg::TOL_W-1:0] tol_reg;
    logic                      busy, job_valid, job_pop, st_we;
    trr_pkg::job_t             job;
    logic [trr_pkg::IDX_W-1:0] st_addr, val_raddr, key_raddr;
    logic [trr_pkg::VAL_W-1:0] st_value, val_rdata;
    logic [trr_pkg::KEY_W-1:0] st_key, key_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (cfg_we)
        begin
            tol_reg <= cfg_wdata;
        end
    end

    trr_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .back_busy(busy),
        .job_pop(job_pop), .job_valid(job_valid), .job(job),
        .st_we(st_we), .st_addr(st_addr), .st_value(st_value), .st_key(st_key));

    trr_ram #(.WIDTH(trr_pkg::VAL_W), .DEPTH(trr_pkg::MAX_CELLS)) u_val (
        .clk(clk), .we(st_we), .waddr(st_addr), .wdata(st_value),
        .raddr(val_raddr), .rdata(val_rdata));

    trr_ram #(.WIDTH(trr_pkg::KEY_W), .DEPTH(trr_pkg::MAX_CELLS)) u_key (
        .clk(clk), .we(st_we), .waddr(st_addr), .wdata(st_key),
        .raddr(key_raddr), .rdata(key_rdata));

    trr_back u_back (
        .clk(clk), .rst_n(rst_n), .tolerance(tol_reg),
        .job_valid(job_valid), .job(job), .job_pop(job_pop), .busy(busy),
        .val_raddr(val_raddr), .val_rdata(val_rdata),
        .key_raddr(key_raddr), .key_rdata(key_rdata), .out_ch(out_ch));
endmodule
`default_nettype wire

// ===== design/trr_checker.sv =====
// Port-level checks for the tolerant rank block, bound to the top level.
`default_nettype none
module trr_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [trr_pkg::IDX_W-1:0]    out_cell_index,
    input wire logic [trr_pkg::RANK_W-1:0]   out_rank,
    input wire logic                         out_last
);
    // held beat keeps its rank, cell index and last flag
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_rank)
            && $stable(out_cell_index) && $stable(out_last))
        else $error("result beat changed under stall");

    a_rank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_rank != '0)
            && (out_rank <= trr_pkg::RANK_W'(trr_pkg::MAX_CELLS)))
        else $error("rank out of range");

    // ranks come out in arrival order without gaps
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> !out_valid
            || (out_cell_index == trr_pkg::IDX_W'($past(out_cell_index) + 1'b1)))
        else $error("cell index skipped");
endmodule

bind tolerant_rank_random_ties trr_checker u_trr_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_cell_index(out_ch.cell_index), .out_rank(out_ch.rank),
    .out_last(out_ch.last_rank));
`default_nettype wire
